>>> rtl/m3i_pkg.sv
package m3i_pkg;

  localparam int EntryW   = 32;
  localparam int FracBits = 16;

  localparam int ProdW    = 2 * EntryW;                 // entry x entry
  localparam int AdjW     = 2 * EntryW + 1;             // signed cofactor
  localparam int HiW      = AdjW - EntryW;              // upper slice of a cofactor
  localparam int PartW    = EntryW + HiW;               // entry x cofactor slice
  localparam int DetW     = 3 * EntryW + 1;             // signed determinant
  localparam int MagW     = 3 * EntryW;                 // |det|
  localparam int AdjMagW  = 2 * EntryW;                 // |cofactor|
  localparam int NumW     = AdjMagW + 2 * FracBits;     // |cofactor| << 2F
  localparam int RemW     = MagW;                       // divider remainder
  localparam int QuotW    = EntryW;                     // quotient bits formed
  localparam int DivSteps = QuotW;

  localparam int CofStages = 2;
  localparam int DetStages = 6;
  localparam int PipeDepth = CofStages + DetStages + DivSteps + 1;

  localparam int TdataW = 9 * EntryW;
  localparam int TuserW = 2;
  localparam int UserSing = 0;
  localparam int UserOvf  = 1;

  localparam logic [EntryW-1:0] MaxPos = {1'b0, {(EntryW-1){1'b1}}};
  localparam logic [EntryW-1:0] MinNeg = {1'b1, {(EntryW-1){1'b0}}};

  // cyclic neighbours of a row or column index
  localparam int Nxt1 [3] = '{1, 2, 0};
  localparam int Nxt2 [3] = '{2, 0, 1};

  typedef logic [8:0][EntryW-1:0] mat_t;

  typedef struct packed {
    logic [8:0][AdjW-1:0]   adj;
    logic [2:0][EntryW-1:0] row0;
  } cof_t;

  typedef struct packed {
    logic [8:0][RemW-1:0]  rem;
    logic [8:0][QuotW-1:0] ql;
    logic [8:0]            neg;
    logic [8:0]            big;
    logic [MagW-1:0]       dmag;
    logic                  sing;
  } div_t;

  typedef struct packed {
    logic [8:0][EntryW-1:0] inv;
    logic                   ovf;
    logic                   sing;
  } res_t;

endpackage

>>> rtl/m3i_cofactor.sv
module m3i_cofactor import m3i_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  mat_t mat_i,
  output logic ready_o,
  output logic valid_o,
  output cof_t cof_o,
  input  logic ready_i
);

  logic v1_q, v2_q, en1, en2;
  logic signed [ProdW-1:0] pa_d [9];
  logic signed [ProdW-1:0] pb_d [9];
  logic signed [ProdW-1:0] pa_q [9];
  logic signed [ProdW-1:0] pb_q [9];
  logic [2:0][EntryW-1:0]  row0_q;
  cof_t                    cof_d, cof_q;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;
  assign cof_o   = cof_q;

  // adj(i,j) is the cofactor of element (j,i)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pa_d[i*3+j] = ProdW'($signed(mat_i[Nxt1[j]*3 + Nxt1[i]]))
                    * ProdW'($signed(mat_i[Nxt2[j]*3 + Nxt2[i]]));
        pb_d[i*3+j] = ProdW'($signed(mat_i[Nxt1[j]*3 + Nxt2[i]]))
                    * ProdW'($signed(mat_i[Nxt2[j]*3 + Nxt1[i]]));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cof_d.adj[k] = AdjW'(pa_q[k]) - AdjW'(pb_q[k]);
    end
    cof_d.row0 = row0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      row0_q <= mat_i[2:0];
    end
    if (en2 && v1_q) begin
      cof_q <= cof_d;
    end
  end

endmodule

>>> rtl/m3i_det.sv
module m3i_det import m3i_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  cof_t cof_i,
  output logic ready_o,
  output logic valid_o,
  output div_t div_o,
  input  logic ready_i
);

  logic [DetStages-1:0] v_q, en;

  logic signed [PartW-1:0] plo_d [3];
  logic signed [PartW-1:0] phi_d [3];
  logic signed [PartW-1:0] plo_q [3];
  logic signed [PartW-1:0] phi_q [3];
  logic signed [DetW-1:0]  p_q [3];
  logic signed [DetW-1:0]  s_q, p2_q, det_q;
  logic [8:0][AdjW-1:0]    adj3_q, adj4_q, adj5_q, adj6_q;
  logic [8:0][AdjMagW-1:0] amag_d, amag_q;
  logic [8:0]              neg_d, neg_q;
  logic [MagW-1:0]         dmag_q;
  logic                    sing_q;
  logic [NumW-1:0]         num [9];
  div_t                    div_d, div_q;

  always_comb begin
    en[DetStages-1] = !v_q[DetStages-1] || ready_i;
    for (int k = DetStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[DetStages-1];
  assign div_o   = div_q;

  // det = sum of row 0 times the first column of the adjugate; each
  // cofactor is split so the products stay near entry width
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      plo_d[k] = PartW'($signed(cof_i.row0[k]))
               * PartW'($signed({1'b0, cof_i.adj[k*3][EntryW-1:0]}));
      phi_d[k] = PartW'($signed(cof_i.row0[k]))
               * PartW'($signed(cof_i.adj[k*3][AdjW-1:EntryW]));
    end
  end

  always_comb begin
    for (int l = 0; l < 9; l++) begin
      amag_d[l] = adj6_q[l][AdjW-1] ? AdjMagW'(-adj6_q[l]) : AdjMagW'(adj6_q[l]);
      neg_d[l]  = adj6_q[l][AdjW-1] ^ det_q[DetW-1];
    end
  end

  always_comb begin
    for (int l = 0; l < 9; l++) begin
      num[l]        = NumW'(amag_q[l]) << (2 * FracBits);
      div_d.rem[l]  = RemW'(num[l] >> EntryW);
      div_d.ql[l]   = num[l][EntryW-1:0];
      div_d.big[l]  = RemW'(num[l] >> EntryW) >= dmag_q;
    end
    div_d.neg  = neg_q;
    div_d.dmag = dmag_q;
    div_d.sing = sing_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < DetStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      adj3_q <= cof_i.adj;
    end
    if (en[1] && v_q[0]) begin
      for (int k = 0; k < 3; k++) begin
        p_q[k] <= (DetW'(phi_q[k]) <<< EntryW) + DetW'(plo_q[k]);
      end
      adj4_q <= adj3_q;
    end
    if (en[2] && v_q[1]) begin
      s_q    <= p_q[0] + p_q[1];
      p2_q   <= p_q[2];
      adj5_q <= adj4_q;
    end
    if (en[3] && v_q[2]) begin
      det_q  <= s_q + p2_q;
      adj6_q <= adj5_q;
    end
    if (en[4] && v_q[3]) begin
      dmag_q <= det_q[DetW-1] ? MagW'(-det_q) : MagW'(det_q);
      sing_q <= det_q == '0;
      amag_q <= amag_d;
      neg_q  <= neg_d;
    end
    if (en[5] && v_q[4]) begin
      div_q <= div_d;
    end
  end

endmodule

>>> rtl/m3i_div_step.sv
module m3i_div_step import m3i_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  div_t div_i,
  output logic ready_o,
  output logic valid_o,
  output div_t div_o,
  input  logic ready_i
);

  logic         v_q, en;
  logic [RemW:0] t   [9];
  logic [8:0]    ge;
  div_t          div_d, div_q;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign div_o   = div_q;

  // one restoring step per lane; the low dividend bits shift out of ql as
  // the quotient bits shift in
  always_comb begin
    div_d = div_i;
    for (int l = 0; l < 9; l++) begin
      t[l]  = {div_i.rem[l], div_i.ql[l][QuotW-1]};
      ge[l] = t[l] >= {1'b0, div_i.dmag};
      div_d.rem[l] = ge[l] ? RemW'(t[l] - {1'b0, div_i.dmag}) : t[l][RemW-1:0];
      div_d.ql[l]  = {div_i.ql[l][QuotW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      div_q <= div_d;
    end
  end

endmodule

>>> rtl/m3i_sat.sv
module m3i_sat import m3i_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  div_t div_i,
  output logic ready_o,
  output logic valid_o,
  output res_t res_o,
  input  logic ready_i
);

  logic v_q, en;
  logic [8:0] sat;
  res_t res_d, res_q;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign res_o   = res_q;

  always_comb begin
    for (int l = 0; l < 9; l++) begin
      sat[l] = 1'b0;
      if (div_i.sing) begin
        res_d.inv[l] = '0;
      end else if (div_i.neg[l]) begin
        sat[l]       = div_i.big[l] || (div_i.ql[l] > MinNeg);
        res_d.inv[l] = sat[l] ? MinNeg : EntryW'(-div_i.ql[l]);
      end else begin
        sat[l]       = div_i.big[l] || (div_i.ql[l] > MaxPos);
        res_d.inv[l] = sat[l] ? MaxPos : div_i.ql[l];
      end
    end
    res_d.ovf  = |sat;
    res_d.sing = div_i.sing;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      res_q <= res_d;
    end
  end

endmodule

>>> rtl/matrix3x3_inverse.sv
// 3x3 matrix inverse, Q16.16 entries, by adjugate over determinant.
// Input stream: one beat is one matrix, nine 32-bit signed entries on
// s_axis_tdata, row-major from m00 in the lowest bits.
// Output stream: one beat per matrix, the nine inverse entries on
// m_axis_tdata in the same order; m_axis_tuser carries singular (bit 0)
// and overflow (bit 1).
// Pipeline: 2 cofactor stages, 6 determinant stages, 32 divider stages
// (one quotient bit per stage, nine lanes in parallel), 1 output stage.
// Throughput: one matrix per cycle while the receiver keeps m_axis_tready high.
// A singular matrix gives all-zero entries with singular set.
// Saturated entries raise overflow.
// Stalls: each stage holds its beat while the one after it cannot take it, so a
// stalled receiver fills the bubbles first and then stops the input side;
// nothing is dropped or repeated. Up to 41 matrices can be in flight.
// Reset clears all stage valids; the pipeline is empty and ready at once.
module matrix3x3_inverse import m3i_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,  // inv00 inv01 ... inv22
  output logic [TuserW-1:0] m_axis_tuser   // singular overflow
);

  logic cof_valid, cof_ready;
  cof_t cof_data;
  logic dv [DivSteps+1];
  logic dr [DivSteps+1];
  div_t dd [DivSteps+1];
  res_t res;

  m3i_cofactor u_cofactor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .mat_i   (mat_t'(s_axis_tdata)),
    .ready_o (s_axis_tready),
    .valid_o (cof_valid),
    .cof_o   (cof_data),
    .ready_i (cof_ready)
  );

  m3i_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cof_valid),
    .cof_i   (cof_data),
    .ready_o (cof_ready),
    .valid_o (dv[0]),
    .div_o   (dd[0]),
    .ready_i (dr[0])
  );

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    m3i_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[s]),
      .div_i   (dd[s]),
      .ready_o (dr[s]),
      .valid_o (dv[s+1]),
      .div_o   (dd[s+1]),
      .ready_i (dr[s+1])
    );
  end

  m3i_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv[DivSteps]),
    .div_i   (dd[DivSteps]),
    .ready_o (dr[DivSteps]),
    .valid_o (m_axis_tvalid),
    .res_o   (res),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata           = res.inv;
  assign m_axis_tuser[UserSing] = res.sing;
  assign m_axis_tuser[UserOvf]  = res.ovf;

endmodule

>>> rtl/m3i_checker.sv
module m3i_checker import m3i_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [TdataW-1:0] m_axis_tdata,
  input logic [TuserW-1:0] m_axis_tuser
);

  localparam int CntW = $clog2(PipeDepth + 1) + 1;

  logic [CntW-1:0] cnt_q;
  logic            acc_in, acc_out;

  assign acc_in  = s_axis_tvalid && s_axis_tready;
  assign acc_out = m_axis_tvalid && m_axis_tready;

  // beats accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CntW'(acc_in) - CntW'(acc_out);
    end
  end

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("output beat with no matrix in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PipeDepth))
    else $error("more matrices in flight than pipeline stages");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[UserSing]
      |-> m_axis_tdata == '0 && !m_axis_tuser[UserOvf])
    else $error("singular result with non-zero entries or overflow");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output beat changed or vanished");

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/m3i_checker.sv
`timescale 1ns / 100ps

module m3i_scoreboard import m3i_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [TdataW-1:0] m_axis_tdata,  // inv00 inv01 ... inv22
  input  logic [TuserW-1:0] m_axis_tuser,  // singular overflow
  output int                err_cnt_o,
  output int                pending_o,
  output int                sing_cnt_o,
  output int                ovf_cnt_o
);

  res_t inverse_q[$];

  // adjugate over determinant, exact at 128 bits
  function automatic res_t invert_matrix(mat_t m);
    logic signed [127:0] e [3][3];
    logic signed [127:0] adj [3][3];
    logic signed [127:0] det;
    logic [127:0]        num;
    logic [127:0]        dmag;
    logic [127:0]        quo;
    logic                neg;
    res_t                r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e[i][j] = $signed(m[i*3+j]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        adj[i][j] = e[(j+1)%3][(i+1)%3] * e[(j+2)%3][(i+2)%3]
                  - e[(j+1)%3][(i+2)%3] * e[(j+2)%3][(i+1)%3];
      end
    end
    det = e[0][0] * adj[0][0] + e[0][1] * adj[1][0] + e[0][2] * adj[2][0];
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    dmag = (det < 0) ? -det : det;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        neg = (adj[i][j] < 0) != (det < 0);
        num = (adj[i][j] < 0) ? -adj[i][j] : adj[i][j];
        quo = (num << (2 * FracBits)) / dmag;
        if (neg) begin
          if (quo > 128'(MinNeg)) begin
            quo = 128'(MinNeg);
            r.ovf = 1'b1;
          end
          r.inv[i*3+j] = -quo[EntryW-1:0];
        end else begin
          if (quo > 128'(MaxPos)) begin
            quo = 128'(MaxPos);
            r.ovf = 1'b1;
          end
          r.inv[i*3+j] = quo[EntryW-1:0];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    int   errs;
    errs = 0;
    if (!rst_ni) begin
      inverse_q.delete();
      err_cnt_o  <= 0;
      pending_o  <= 0;
      sing_cnt_o <= 0;
      ovf_cnt_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (inverse_q.size() == 0) begin
          $error("unexpected output beat %h", m_axis_tdata);
          errs++;
        end else begin
          exp_r = inverse_q.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (m_axis_tdata[k*EntryW +: EntryW] !== exp_r.inv[k]) begin
              $error("inv%0d%0d expected %h actual %h", k / 3, k % 3, exp_r.inv[k],
                     m_axis_tdata[k*EntryW +: EntryW]);
              errs++;
            end
          end
          if (m_axis_tuser[UserSing] !== exp_r.sing) begin
            $error("singular expected %b actual %b", exp_r.sing, m_axis_tuser[UserSing]);
            errs++;
          end
          if (m_axis_tuser[UserOvf] !== exp_r.ovf) begin
            $error("overflow expected %b actual %b", exp_r.ovf, m_axis_tuser[UserOvf]);
            errs++;
          end
          sing_cnt_o <= sing_cnt_o + exp_r.sing;
          ovf_cnt_o  <= ovf_cnt_o + exp_r.ovf;
        end
      end
      if (errs != 0) err_cnt_o <= err_cnt_o + errs;
      if (s_axis_tvalid && s_axis_tready) inverse_q.push_back(invert_matrix(s_axis_tdata));
      pending_o <= inverse_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import m3i_pkg::*;

  localparam int NumRandom = 730;
  localparam int QuietTail = 120;
  localparam int StallLimit = 5000;
  localparam logic [EntryW-1:0] One = 32'h0001_0000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TdataW-1:0] s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic [TuserW-1:0] m_axis_tuser;
  int                err_cnt, pending, sing_cnt, ovf_cnt;
  int                n_sent = 0;
  int                quiet = 0;
  logic              gaps_on = 1'b1;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  matrix3x3_inverse u_top (.*);

  m3i_scoreboard u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .err_cnt_o(err_cnt), .pending_o(pending), .sing_cnt_o(sing_cnt), .ovf_cnt_o(ovf_cnt)
  );

  // receiver stalls in bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_matrix(input mat_t m);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= m;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  function automatic logic [EntryW-1:0] small_q(input int span);
    return EntryW'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic mat_t diag_matrix(input logic [EntryW-1:0] a, b, c);
    mat_t m;
    m = '0;
    m[0] = a;
    m[4] = b;
    m[8] = c;
    return m;
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    int   kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0, 1:    m[k] = $urandom();
        2, 3, 4: m[k] = small_q(1 << 19);    // within +-8.0
        5:       m[k] = small_q(4);          // tiny entries, inverse may saturate
        default: m[k] = small_q(1 << 17);
      endcase
    end
    if (kind == 6) for (int c = 0; c < 3; c++) m[6+c] = m[c];   // repeated row
    if (kind == 7) for (int r = 0; r < 3; r++) m[r*3+2] = '0;    // zero column
    if (kind == 8) m = diag_matrix(small_q(1 << 20), small_q(1 << 20), small_q(1 << 20));
    return m;
  endfunction

  initial begin
    mat_t m;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_matrix(diag_matrix(One, One, One));
    send_matrix('0);
    send_matrix({9{MaxPos}});
    send_matrix({9{MinNeg}});
    send_matrix(diag_matrix(MaxPos, MaxPos, MaxPos));
    send_matrix(diag_matrix(MinNeg, MinNeg, MinNeg));
    send_matrix(diag_matrix(MinNeg, MaxPos, MinNeg));
    send_matrix(diag_matrix(32'd1, 32'd1, 32'd1));
    send_matrix(diag_matrix(-32'sd1, 32'd1, -32'sd1));
    send_matrix(diag_matrix(32'd1, 32'd1, 32'h4000_0000));
    send_matrix(diag_matrix(-One, 2 * One, One >> 1));
    send_matrix({9{32'hFFFF_FFFF}});
    send_matrix({9{32'h5555_5555}});
    send_matrix({9{32'hAAAA_AAAA}});
    m = '0;
    m[2] = One; m[4] = One; m[6] = One;            // anti-diagonal permutation
    send_matrix(m);
    m = diag_matrix(One, One, One);
    m[1] = MaxPos; m[5] = MinNeg;                  // shear, large cofactors
    send_matrix(m);
    m = diag_matrix(MinNeg, 32'd1, 32'd1);
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = EntryW'(k + 1) * One;   // rank two
    send_matrix(m);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if (n == NumRandom - QuietTail) gaps_on = 1'b0;
      send_matrix(random_matrix());
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);

    $display("sent %0d matrices: %0d singular, %0d with saturated entries",
             n_sent, sing_cnt, ovf_cnt);
    $display("stall bursts on both sides, one full drain, unstalled tail");
    if (err_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/m3i_pkg.sv
rtl/m3i_cofactor.sv
rtl/m3i_det.sv
rtl/m3i_div_step.sv
rtl/m3i_sat.sv
rtl/matrix3x3_inverse.sv
rtl/m3i_checker.sv
tb/m3i_checker.sv
tb/tb_top.sv
